FILE: rtl/core/icg_pkg.sv
`default_nettype none
package icg_pkg;
   localparam int StateBits = 31;
   localparam int ProdBits  = 2 * StateBits;
   localparam logic [StateBits-1:0] ModulusReset    = 31'd2147483053;
   localparam logic [StateBits-1:0] MultiplierReset = 31'd22211;
   localparam logic [StateBits-1:0] IncrementReset  = 31'd11926380;
   localparam logic [StateBits-1:0] StateReset      = 31'd1;

   localparam logic CmdNext = 1'b0;
   localparam logic CmdSeed = 1'b1;

   localparam logic [3:0] AddrModulus    = 4'd0;
   localparam logic [3:0] AddrMultiplier = 4'd4;
   localparam logic [3:0] AddrIncrement  = 4'd8;

   typedef enum logic [3:0] {
      OP_IDLE, OP_LOAD_SEED, OP_LOAD_STATE, OP_RED_STEP, OP_EUC_INIT,
      OP_DIV_STEP, OP_EUC_UPDATE, OP_MUL_STEP, OP_SUM_INIT, OP_COMMIT_SEED,
      OP_COMMIT_NEXT
   } op_type;

   typedef struct packed {
      logic div_done;
      logic euc_done;
      logic mul_done;
      logic small_state;
   } status_type;
endpackage
`default_nettype wire

FILE: rtl/core/icg_datapath.sv
`default_nettype none
module icg_datapath
   import icg_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire op_type               op,
   input  wire logic [StateBits-1:0] seed_value,
   input  wire logic [StateBits-1:0] modulus,
   input  wire logic [StateBits-1:0] multiplier,
   input  wire logic [StateBits-1:0] increment,
   output status_type                status,
   output logic [StateBits-1:0]      result
);
   localparam int CntBits = $clog2(ProdBits + 1);

   // Shared restoring divider: dividend shifted out MSB first, remainder built up.
   logic [StateBits-1:0] state_ff, state_in;
   logic [ProdBits-1:0]  dvd_ff, dvd_in;
   logic [StateBits:0]   rem_ff, rem_in;
   logic [ProdBits-1:0]  quo_ff, quo_in;
   logic [StateBits-1:0] dsr_ff, dsr_in;
   logic [CntBits-1:0]   cnt_ff, cnt_in;
   logic [StateBits-1:0] u_ff, u_in;
   logic signed [StateBits+1:0] prev_ff, prev_in, cur_ff, cur_in;
   logic [ProdBits-1:0]  acc_ff, acc_in;
   logic [StateBits-1:0] mcand_ff, mcand_in;
   logic [StateBits-1:0] mplier_ff, mplier_in;

   logic [StateBits+1:0] trial;
   logic [StateBits:0]   shifted;
   logic signed [ProdBits+3:0] qc;
   logic signed [StateBits+1:0] inv_s;
   logic [StateBits-1:0] inv;

   always_comb begin
      shifted = {rem_ff[StateBits-1:0], dvd_ff[ProdBits-1]};
      trial = {1'b0, shifted} - {2'b00, dsr_ff};
      qc = $signed({{(ProdBits-StateBits-2){1'b0}}, quo_ff[StateBits+1:0]}) * cur_ff;
      inv_s = (cur_ff < 0) ? cur_ff + $signed({2'b00, modulus}) : cur_ff;
      inv = inv_s[StateBits-1:0];
   end

   always_comb begin
      state_in = state_ff; dvd_in = dvd_ff; rem_in = rem_ff; quo_in = quo_ff;
      dsr_in = dsr_ff; cnt_in = cnt_ff; u_in = u_ff;
      prev_in = prev_ff; cur_in = cur_ff; acc_in = acc_ff;
      mcand_in = mcand_ff; mplier_in = mplier_ff;
      unique case (op)
         OP_LOAD_SEED, OP_LOAD_STATE: begin
            dvd_in = {(op == OP_LOAD_SEED ? seed_value : state_ff),
                      {(ProdBits-StateBits){1'b0}}};
            rem_in = '0; quo_in = '0; dsr_in = modulus;
            cnt_in = CntBits'(StateBits);
         end
         OP_SUM_INIT: begin
            dvd_in = acc_ff; rem_in = '0; quo_in = '0; dsr_in = modulus;
            cnt_in = CntBits'(ProdBits);
         end
         OP_RED_STEP, OP_DIV_STEP: begin
            dvd_in = {dvd_ff[ProdBits-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (dsr_ff != '0 && !trial[StateBits+1]) begin
               rem_in = trial[StateBits:0];
               quo_in = {quo_ff[ProdBits-2:0], 1'b1};
            end else begin
               rem_in = (dsr_ff == '0) ? '0 : shifted;
               quo_in = {quo_ff[ProdBits-2:0], 1'b0};
            end
         end
         OP_EUC_INIT: begin
            u_in = rem_ff[StateBits-1:0];
            prev_in = '0; cur_in = 'sd1;
            dvd_in = {modulus, {(ProdBits-StateBits){1'b0}}};
            rem_in = '0; quo_in = '0; dsr_in = rem_ff[StateBits-1:0];
            cnt_in = CntBits'(StateBits);
            mplier_in = rem_ff[StateBits-1:0];
         end
         OP_EUC_UPDATE: begin
            u_in = rem_ff[StateBits-1:0];
            prev_in = cur_ff;
            cur_in = prev_ff - qc[StateBits+1:0];
            dvd_in = {u_ff, {(ProdBits-StateBits){1'b0}}};
            rem_in = '0; quo_in = '0; dsr_in = rem_ff[StateBits-1:0];
            cnt_in = CntBits'(StateBits);
            if (rem_ff[StateBits-1:0] == '0) begin
               mcand_in = multiplier;
               mplier_in = (mplier_ff <= 1) ? mplier_ff : inv;
               acc_in = {{(ProdBits-StateBits){1'b0}}, increment};
               cnt_in = CntBits'(StateBits);
            end
         end
         OP_MUL_STEP: begin
            if (mplier_ff[0])
               acc_in = acc_ff + ({{(ProdBits-StateBits){1'b0}}, mcand_ff}
                                  << (StateBits - int'(cnt_ff)));
            mplier_in = mplier_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
         end
         OP_COMMIT_SEED, OP_COMMIT_NEXT: state_in = rem_ff[StateBits-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
      end else begin
         state_ff <= state_in;
      end
      dvd_ff <= dvd_in; rem_ff <= rem_in; quo_ff <= quo_in; dsr_ff <= dsr_in;
      cnt_ff <= cnt_in; u_ff <= u_in; prev_ff <= prev_in;
      cur_ff <= cur_in; acc_ff <= acc_in; mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign status.div_done    = (cnt_ff == CntBits'(1));
   assign status.euc_done    = (rem_ff[StateBits-1:0] == '0);
   assign status.mul_done    = (cnt_ff == CntBits'(1));
   assign status.small_state = (rem_ff[StateBits-1:0] <= 1);
   assign result = rem_ff[StateBits-1:0];
endmodule
`default_nettype wire

FILE: rtl/core/icg_controller.sv
`default_nettype none
module icg_controller
   import icg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       command,
   input  wire status_type status,
   input  wire logic       out_free,
   output logic            busy,
   output logic            result_valid,
   output op_type          op
);
   typedef enum logic [3:0] {
      S_IDLE, S_RED_SEED, S_RED_STATE, S_INV_CHECK, S_DIV, S_UPDATE,
      S_MUL, S_SUM, S_DONE_SEED, S_DONE_NEXT, S_WAIT_OUT
   } state_type;

   state_type st_ff, st_in;

   always_comb begin
      st_in = st_ff;
      op = OP_IDLE;
      unique case (st_ff)
         S_IDLE: if (start) begin
            op = (command == CmdSeed) ? OP_LOAD_SEED : OP_LOAD_STATE;
            st_in = (command == CmdSeed) ? S_RED_SEED : S_RED_STATE;
         end
         S_RED_SEED: begin
            op = OP_RED_STEP;
            if (status.div_done) st_in = S_DONE_SEED;
         end
         S_RED_STATE: begin
            op = OP_RED_STEP;
            if (status.div_done) st_in = S_INV_CHECK;
         end
         S_INV_CHECK: begin
            op = OP_EUC_INIT;
            st_in = status.small_state ? S_UPDATE : S_DIV;
         end
         S_DIV: begin
            op = OP_DIV_STEP;
            if (status.div_done) st_in = S_UPDATE;
         end
         S_UPDATE: begin
            op = OP_EUC_UPDATE;
            st_in = status.euc_done ? S_MUL : S_DIV;
         end
         S_MUL: begin
            op = OP_MUL_STEP;
            if (status.mul_done) st_in = S_SUM;
         end
         S_SUM: begin
            op = OP_SUM_INIT;
            st_in = S_DONE_NEXT;
         end
         S_DONE_NEXT: begin
            op = OP_RED_STEP;
            if (status.div_done) st_in = S_WAIT_OUT;
         end
         S_WAIT_OUT: if (out_free) begin
            op = OP_COMMIT_NEXT;
            st_in = S_IDLE;
         end
         S_DONE_SEED: begin
            op = OP_COMMIT_SEED;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   assign busy = (st_ff != S_IDLE);
   assign result_valid = (op == OP_COMMIT_NEXT);
endmodule
`default_nettype wire

FILE: rtl/core/inversive_congruential_prng_top.sv
`default_nettype none
// Inversive congruential generator. A next word takes the stored state through
// a reduction, an extended Euclidean inversion that runs every quotient on one
// shared bit-serial divider, a shift-add multiply and a final reduction. When
// the reduced state is zero or one, the inversion does no divisions. A finished
// result may wait for the output register to drain before it commits; a seed
// word takes only the reduction before it is stored as the new state. One word
// is processed at a time, and a finished result is held in an output register.
module inversive_congruential_prng_top
   import icg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // seed_value[30:0], zero pad
   input  wire logic        req_tuser,  // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // random_value[30:0], zero pad
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   logic [StateBits-1:0] mod_ff, mul_ff, inc_ff, dp_result;
   logic busy, result_valid, out_valid_ff;
   logic [StateBits-1:0] out_ff;
   status_type status;
   op_type op;
   logic wr, start;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= ModulusReset; mul_ff <= MultiplierReset; inc_ff <= IncrementReset;
      end else if (wr) begin
         unique case (csr_paddr)
            AddrModulus:    mod_ff <= csr_pwdata[StateBits-1:0];
            AddrMultiplier: mul_ff <= csr_pwdata[StateBits-1:0];
            AddrIncrement:  inc_ff <= csr_pwdata[StateBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         AddrModulus:    csr_prdata = {1'b0, mod_ff};
         AddrMultiplier: csr_prdata = {1'b0, mul_ff};
         AddrIncrement:  csr_prdata = {1'b0, inc_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign req_tready = !busy;
   assign start = req_tvalid && req_tready;

   icg_controller u_ctrl (
      .clock, .reset, .start, .command(req_tuser), .status,
      .out_free(!out_valid_ff || rsp_tready), .busy, .result_valid, .op
   );

   icg_datapath u_dp (
      .clock, .reset, .op, .seed_value(req_tdata[StateBits-1:0]),
      .modulus(mod_ff), .multiplier(mul_ff), .increment(inc_ff), .status,
      .result(dp_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (result_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) out_ff <= dp_result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {1'b0, out_ff};
endmodule
`default_nettype wire

FILE: rtl/core/icg_checker.sv
`default_nettype none
module icg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[31]) else $error("pad bit set");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("accepted twice");
   a_rst: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("valid after reset");
endmodule

bind inversive_congruential_prng_top icg_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
`default_nettype wire

FILE: tb/inversive_congruential_prng_top_test.sv
`timescale 1ns / 1ps
module inversive_congruential_prng_top_test;
   import icg_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = CmdNext;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   inversive_congruential_prng_top dut (.*);

   always #5 clock = ~clock;

   typedef struct {
      logic        cmd;
      logic [30:0] seed;
      bit          fixed;
      logic [30:0] value;
   } stim_row_type;

   typedef struct {
      logic [30:0] p;
      logic [30:0] a;
      logic [30:0] b;
   } setting_type;

   logic [30:0] modulus_q, multiplier_q, increment_q, state_q;
   logic [30:0] draws_pending[$];
   int          mismatches = 0;
   int          draws_seen = 0;
   int          seeds_sent = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   logic        hold_off = 1'b0;
   int          cycle_count = 0;

   function automatic logic [30:0] icg_next(logic [30:0] st);
      longint unsigned p, s, inv, d, u, q, r, sum;
      longint          prv, cur, nx;
      p = {33'd0, modulus_q};
      s = (p == 0) ? 0 : {33'd0, st} % p;
      if (s <= 1) begin
         inv = s;
      end else begin
         d = p;
         u = s;
         prv = 0;
         cur = 1;
         while (u != 0) begin
            q = d / u;
            r = d % u;
            nx = prv - longint'(q) * cur;
            d = u;
            u = r;
            prv = cur;
            cur = nx;
         end
         if (prv < 0) prv += longint'(p);
         inv = longint'(prv);
      end
      sum = {33'd0, multiplier_q} * inv + {33'd0, increment_q};
      return (p == 0) ? 31'd0 : 31'(sum % p);
   endfunction

   task automatic csr_write(logic [3:0] addr, logic [30:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {1'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_word(logic cmd, logic [30:0] seed, bit fixed, logic [30:0] value);
      logic [30:0] nxt;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {1'b0, seed};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      if (cmd == CmdSeed) begin
         state_q = (modulus_q == 0) ? 31'd0 : 31'({33'd0, seed} % {33'd0, modulus_q});
         seeds_sent++;
      end else begin
         nxt = icg_next(state_q);
         state_q = nxt;
         draws_pending.push_back(fixed ? value : nxt);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (draws_pending.size() != 0) @(posedge clock);
      repeat (2500) @(posedge clock);
   endtask

   function automatic logic [30:0] pick_seed();
      case ($urandom_range(0, 3))
         0: return 31'($urandom);
         1: return 31'($urandom_range(0, 3));
         2: return modulus_q + 31'($urandom_range(0, 2));
         default: return 31'h7FFF_FFFF - 31'($urandom_range(0, 1));
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         draws_seen++;
         if (draws_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected word %0d", rsp_tdata);
         end else if (rsp_tdata !== {1'b0, draws_pending[0]}) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected %0d, got %0d", draws_pending[0], rsp_tdata);
            void'(draws_pending.pop_front());
         end else begin
            void'(draws_pending.pop_front());
         end
      end
      if (hold_off) rsp_tready <= 1'b0;
      else if (cycle_count[8]) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= 1'b1;
   end

   initial begin
      repeat (20000) @(posedge clock);
      hold_off <= 1'b1;
      repeat (20000) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #200ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      setting_type  settings[$];
      int           per_phase;
      rows = '{
         '{CmdNext, 31'd0, 1, 31'd11948591},
         '{CmdSeed, 31'd0, 0, 31'd0},
         '{CmdNext, 31'd0, 1, 31'd11926380},
         '{CmdSeed, 31'd1, 0, 31'd0},
         '{CmdNext, 31'h7FFF_FFFF, 1, 31'd11948591},
         '{CmdSeed, 31'd2147483053, 0, 31'd0},
         '{CmdNext, 31'd0, 1, 31'd11926380},
         '{CmdSeed, 31'd2147483054, 0, 31'd0},
         '{CmdNext, 31'd0, 1, 31'd11948591},
         '{CmdSeed, 31'h7FFF_FFFF, 0, 31'd0},
         '{CmdNext, 31'd0, 0, 31'd0},
         '{CmdNext, 31'd0, 0, 31'd0},
         '{CmdSeed, 31'd2, 0, 31'd0},
         '{CmdNext, 31'd0, 0, 31'd0},
         '{CmdSeed, 31'd2147483052, 0, 31'd0},
         '{CmdNext, 31'h5555_5555, 0, 31'd0},
         '{CmdNext, 31'h2AAA_AAAA, 0, 31'd0}
      };
      settings = '{
         '{31'd7, 31'd3, 31'd2},
         '{31'd2147483647, 31'd2147483646, 31'd2147483646},
         '{31'd3, 31'd1, 31'd0},
         '{31'd12, 31'd5, 31'd7},
         '{31'd0, 31'd5, 31'd3},
         '{31'd1, 31'd9, 31'd9},
         '{31'd65521, 31'd0, 31'd65520},
         '{31'd13, 31'd100, 31'd200},
         '{31'd97, 31'd96, 31'd0},
         '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF},
         '{31'd2147483053, 31'd22211, 31'd11926380}
      };
      modulus_q = ModulusReset;
      multiplier_q = MultiplierReset;
      increment_q = IncrementReset;
      state_q = StateReset;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_word(rows[i].cmd, rows[i].seed, rows[i].fixed, rows[i].value);
      per_phase = (1850 - rows.size()) / settings.size();
      foreach (settings[k]) begin
         drain();
         csr_write(AddrModulus, settings[k].p);
         csr_write(AddrMultiplier, settings[k].a);
         csr_write(AddrIncrement, settings[k].b);
         modulus_q = settings[k].p;
         multiplier_q = settings[k].a;
         increment_q = settings[k].b;
         repeat (per_phase) begin
            if ($urandom_range(0, 4) == 0) send_word(CmdSeed, pick_seed(), 0, 31'd0);
            else send_word(CmdNext, 31'($urandom), 0, 31'd0);
         end
      end
      drain();
      $display("Sent %0d words (%0d seeds) over %0d register settings.",
               words_sent, seeds_sent, settings.size() + 1);
      $display("Checked %0d draws, %0d mismatches.", draws_seen, mismatches);
      if (mismatches == 0 && draws_pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

FILE: files.f
rtl/core/icg_pkg.sv
rtl/core/icg_datapath.sv
rtl/core/icg_controller.sv
rtl/core/inversive_congruential_prng_top.sv
rtl/core/icg_checker.sv
tb/inversive_congruential_prng_top_test.sv
